// ===== rtl/ntt_pkg.sv =====
// Shared types, constants and helpers for the note-off timer table.
// No dependencies; every other file but ntt_ram imports this package.
package ntt_pkg;

  localparam int PORTS          = 16;
  localparam int NOTES_PER_SCAN = 64;
  localparam int CHANNELS       = 16;
  localparam int NOTES          = 128;

  localparam int TIMER_W    = 31;
  localparam int PERIOD_W   = 24;
  localparam int COUNT_W    = 12;
  localparam int SUB_SHIFT  = 11;
  localparam int DEPTH      = PORTS * CHANNELS * NOTES;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int PORT_IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int SCAN_CNT_W = $clog2(NOTES_PER_SCAN + 1);
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(2048);
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
  localparam logic [6:0]          NOTE_OFF_VEL = 7'd64;
  localparam logic [0:0]          REG_PERIOD   = 1'b0;

  localparam logic [1:0] CMD_SCHED = 2'd0;
  localparam logic [1:0] CMD_IMM   = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_DUP      = 3'd2;
  localparam logic [2:0] KIND_IMM      = 3'd3;
  localparam logic [2:0] KIND_IGNORED  = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  port;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [18:0] duration;
    logic [18:0] time_offset;
    logic        note_group;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  out_port;
    logic [3:0]  out_channel;
    logic [6:0]  out_note;
    logic [6:0]  velocity;
    logic [12:0] offset_ticks;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [TIMER_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCHED,
    ST_IMM,
    ST_EMIT,
    ST_SCAN
  } seq_state_e;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [3:0] port,
                                                  input logic [3:0] channel,
                                                  input logic [6:0] note);
    return ADDR_W'({port, channel, note});
  endfunction

endpackage

// ===== rtl/ntt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while no read is issued. No dependencies.
module ntt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ntt_apb.sv =====
// APB configuration register: subticks per period.
// Depends on ntt_pkg.
module ntt_apb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ntt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ntt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ntt_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [ntt_pkg::PERIOD_W-1:0]  period_o
);
  import ntt_pkg::*;

  logic [PERIOD_W-1:0] period_q, period_d;
  logic                sel_period;

  assign sel_period = (paddr[APB_ADDR_W-1:2] == REG_PERIOD);

  always_comb begin
    period_d = period_q;
    if (psel && penable && pwrite && sel_period) begin
      period_d = pwdata[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else begin
      period_q <= period_d;
    end
  end

  assign prdata   = sel_period ? APB_DATA_W'(period_q) : '0;
  assign pready   = 1'b1;
  assign period_o = period_q;

endmodule

// ===== rtl/ntt_seq.sv =====
// Sequencer: memory clear, note-on read-modify-write, scan loop, port counts,
// pending note-off hold and output register. Depends on ntt_pkg.
module ntt_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ntt_pkg::in_word_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ntt_pkg::out_word_t           out_data_o,
  input  logic [ntt_pkg::PERIOD_W-1:0] period_i,
  output ntt_pkg::ram_req_t            ram_req_o,
  input  logic [ntt_pkg::TIMER_W-1:0]  ram_rdata_i
);
  import ntt_pkg::*;

  seq_state_e state_q, state_d;
  in_word_t   item_q, item_d;
  out_word_t  out_q, out_d, hold_q, hold_d;
  logic       out_valid_q, out_valid_d, hold_valid_q, hold_valid_d;
  logic       p_valid_q, p_valid_d;
  logic [6:0] p_note_q, p_note_d;
  logic [7:0] iss_note_q, iss_note_d;
  logic [SCAN_CNT_W-1:0] iss_cnt_q, iss_cnt_d;
  logic [ADDR_W-1:0]     clr_addr_q, clr_addr_d;
  logic [COUNT_W-1:0]    counts_q [PORTS];
  logic [COUNT_W-1:0]    cur_count;

  logic [PORT_IDX_W-1:0] item_idx, in_idx;
  logic                  in_port_ok, item_port_ok;
  logic                  out_free, cnt_inc, cnt_dec;
  logic                  live, expire, stall, issue_done;
  logic [TIMER_W-1:0]    period_ext;
  logic [19:0]           sched_ticks;
  out_word_t             echo_word;

  assign in_idx       = PORT_IDX_W'(in_data_i.port);
  assign item_idx     = PORT_IDX_W'(item_q.port);
  assign in_port_ok   = (32'(in_data_i.port) < PORTS);
  assign item_port_ok = (32'(item_q.port) < PORTS);
  assign cur_count    = counts_q[item_idx];
  assign out_free     = !out_valid_q || out_ready_i;
  assign period_ext   = TIMER_W'(period_i);
  assign sched_ticks  = 20'(item_q.duration) + 20'(item_q.time_offset);

  assign live       = p_valid_q && (ram_rdata_i != '0);
  assign expire     = live && (ram_rdata_i <= period_ext);
  assign stall      = expire && hold_valid_q && !out_free;
  assign issue_done = (iss_cnt_q == SCAN_CNT_W'(NOTES_PER_SCAN)) || iss_note_q[7];

  always_comb begin
    echo_word              = '0;
    echo_word.out_port     = item_q.port;
    echo_word.out_channel  = item_q.channel;
    echo_word.out_note     = item_q.note;
    echo_word.last         = 1'b1;
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    p_valid_d    = p_valid_q;
    p_note_d     = p_note_q;
    iss_note_d   = iss_note_q;
    iss_cnt_d    = iss_cnt_q;
    clr_addr_d   = clr_addr_q;
    cnt_inc      = 1'b0;
    cnt_dec      = 1'b0;
    in_ready_o   = 1'b0;
    ram_req_o    = '0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = clr_addr_q;
        clr_addr_d      = clr_addr_q + 1'b1;
        if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_data_i;
          if (in_data_i.cmd == CMD_SCAN) begin
            if (in_port_ok && (counts_q[in_idx] != '0)) begin
              state_d    = ST_SCAN;
              iss_note_d = in_data_i.note_group ? 8'(NOTES_PER_SCAN) : 8'd0;
              iss_cnt_d  = '0;
              p_valid_d  = 1'b0;
            end
          end else if ((in_data_i.cmd == CMD_RSVD) || !in_port_ok ||
                       ((in_data_i.cmd == CMD_SCHED) && (in_data_i.duration == '0))) begin
            state_d = ST_EMIT;
          end else if (in_data_i.cmd == CMD_IMM) begin
            state_d = ST_IMM;
          end else begin
            state_d         = ST_SCHED;
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = slot_addr(in_data_i.port, in_data_i.channel, in_data_i.note);
          end
        end
      end

      ST_SCHED: begin
        if (out_free) begin
          out_d       = echo_word;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (ram_rdata_i > period_ext) begin
            out_d.kind = KIND_DUP;
          end else begin
            out_d.kind      = KIND_NOTE_ON;
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = slot_addr(item_q.port, item_q.channel, item_q.note);
            ram_req_o.wdata = {sched_ticks, 11'd0};
            cnt_inc         = 1'b1;
          end
        end
      end

      ST_IMM: begin
        if (out_free) begin
          out_d           = echo_word;
          out_d.kind      = KIND_IMM;
          out_valid_d     = 1'b1;
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = slot_addr(item_q.port, item_q.channel, item_q.note);
          ram_req_o.wdata = TIMER_W'({item_q.time_offset, 11'd0});
          cnt_inc         = 1'b1;
          state_d         = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_d       = echo_word;
          out_d.kind  = KIND_IGNORED;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (live && !stall) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = slot_addr(item_q.port, item_q.channel, p_note_q);
          ram_req_o.wdata = expire ? '0 : (ram_rdata_i - period_ext);
          if (expire) begin
            cnt_dec = 1'b1;
            if (hold_valid_q) begin
              out_d       = hold_q;
              out_valid_d = 1'b1;
            end
            hold_d              = '0;
            hold_d.kind         = KIND_NOTE_OFF;
            hold_d.out_port     = item_q.port;
            hold_d.out_channel  = item_q.channel;
            hold_d.out_note     = p_note_q;
            hold_d.velocity     = NOTE_OFF_VEL;
            hold_d.offset_ticks = ram_rdata_i[SUB_SHIFT +: 13];
            hold_valid_d        = 1'b1;
          end
        end
        if (!stall) begin
          if (!issue_done) begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = slot_addr(item_q.port, item_q.channel, iss_note_q[6:0]);
            iss_note_d      = iss_note_q + 1'b1;
            iss_cnt_d       = iss_cnt_q + 1'b1;
            p_valid_d       = 1'b1;
            p_note_d        = iss_note_q[6:0];
          end else begin
            p_valid_d = 1'b0;
          end
        end
        if (issue_done && !p_valid_q) begin
          if (!hold_valid_q) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            out_d        = hold_q;
            out_d.last   = 1'b1;
            out_valid_d  = 1'b1;
            hold_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
      p_valid_q    <= 1'b0;
      iss_note_q   <= '0;
      iss_cnt_q    <= '0;
      clr_addr_q   <= '0;
      for (int i = 0; i < PORTS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
      p_valid_q    <= p_valid_d;
      iss_note_q   <= iss_note_d;
      iss_cnt_q    <= iss_cnt_d;
      clr_addr_q   <= clr_addr_d;
      if (item_port_ok) begin
        if (cnt_inc && (cur_count != COUNT_MAX)) begin
          counts_q[item_idx] <= cur_count + 1'b1;
        end else if (cnt_dec && (cur_count != '0)) begin
          counts_q[item_idx] <= cur_count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    out_q    <= out_d;
    hold_q   <= hold_d;
    p_note_q <= p_note_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/note_off_timer_table.sv =====
// Note-on: the accepted item moves to ST_SCHED, which checks the read timer and
// registers the result word once the output is free. Scan: one timer per cycle
// unless a held note-off waits on a busy output, a rate set by the single read
// port of the timer RAM; a scan of a port with zero count is consumed in ST_IDLE
// with no output. One item in flight at a time. Reset: counts and period register
// reset at once; the timer RAM is then cleared one entry per cycle, with in_ready_o low.
// Depends on ntt_pkg, ntt_ram, ntt_apb, ntt_seq.
module note_off_timer_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ntt_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ntt_pkg::out_word_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ntt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ntt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ntt_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);
  import ntt_pkg::*;

  logic [PERIOD_W-1:0] period;
  ram_req_t            ram_req;
  logic [TIMER_W-1:0]  ram_rdata;

  ntt_apb u_apb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .period_o (period)
  );

  ntt_ram #(
    .WIDTH (TIMER_W),
    .DEPTH (DEPTH)
  ) u_timer_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  ntt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .period_i    (period),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ram_req.we)
    else $error("timer write while idle");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("read and write to same timer in one cycle");

  a_note_off_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind != KIND_NOTE_OFF)) |->
      ((out_data_o.velocity == '0) && (out_data_o.offset_ticks == '0) && out_data_o.last))
    else $error("non note-off word malformed");
`endif

endmodule
